// File: hw/rtl/bflj_pkg.sv
package bflj_pkg;

   localparam int FRAC_BITS_DEF = 20;
   localparam int TRIG_ITER_DEF = 24;

   localparam logic [30:0] INV_MVA_RESET = 31'd10486;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
   localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
   localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
   localparam logic signed [63:0] Q30_GAIN    = 64'sd652032874;

   localparam logic [1:0] KIND_TO_MARGIN = 2'd3;

   typedef struct packed {
      logic signed [31:0] gff;
      logic signed [31:0] bff;
      logic signed [31:0] gft;
      logic signed [31:0] bft;
      logic signed [31:0] gtf;
      logic signed [31:0] btf;
      logic signed [31:0] gtt;
      logic signed [31:0] btt;
      logic signed [31:0] af;
      logic signed [31:0] vmf;
      logic signed [31:0] at;
      logic signed [31:0] vmt;
      logic [30:0]        rating;
      logic               on;
   } item_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic               last;
      logic signed [63:0] value;
      logic signed [63:0] dna;
      logic signed [63:0] dnm;
      logic signed [63:0] dfa;
      logic signed [63:0] dfm;
   } row_type;

   typedef enum logic [2:0] {
      OP_LDF, OP_MUL, OP_ADD, OP_NEG, OP_TRIG, OP_EMV, OP_PUSH, OP_NEXT
   } uop_type;

   typedef struct packed {
      uop_type    op;
      logic [4:0] a;
      logic [4:0] b;
      logic [4:0] d;
   } uinstr_type;

   localparam int PC_W = 7;
   localparam logic [PC_W-1:0] BODY_PC = 7'd4;

   // scratch register addresses
   localparam logic [4:0] R_GS = 5'd0,  R_BS = 5'd1,  R_GT = 5'd2,  R_BT = 5'd3;
   localparam logic [4:0] R_VN = 5'd4,  R_VF = 5'd5,  R_C  = 5'd6,  R_S  = 5'd7;
   localparam logic [4:0] R_VV = 5'd8,  R_VN2 = 5'd9, R_KA = 5'd10, R_KB = 5'd11;
   localparam logic [4:0] R_P  = 5'd12, R_Q  = 5'd13, R_T1 = 5'd14, R_T2 = 5'd15;
   localparam logic [4:0] R_DPFA = 5'd16, R_DPNA = 5'd17, R_DQNA = 5'd18;
   localparam logic [4:0] R_DQFA = 5'd19, R_DPNM = 5'd20, R_DPFM = 5'd21;
   localparam logic [4:0] R_DQNM = 5'd22, R_DQFM = 5'd23, R_S2 = 5'd24;
   localparam logic [4:0] R_D0 = 5'd25, R_D1 = 5'd26, R_D2 = 5'd27, R_D3 = 5'd28;
   localparam logic [4:0] R_SLIM = 5'd31;
   localparam logic [4:0] NOREG = 5'd0;

   // field ids for loads, near/far resolved by the side being evaluated
   localparam logic [4:0] F_GS = 5'd0, F_BS = 5'd1, F_GT = 5'd2, F_BT = 5'd3;
   localparam logic [4:0] F_VN = 5'd4, F_VF = 5'd5, F_RAT = 5'd6, F_INV = 5'd7;

   localparam logic [4:0] SLOT_VAL = 5'd0, SLOT_D0 = 5'd1, SLOT_D1 = 5'd2;
   localparam logic [4:0] SLOT_D2 = 5'd3, SLOT_D3 = 5'd4;
   localparam logic [4:0] MARGIN_NO = 5'd0, MARGIN_YES = 5'd1;

   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
      return s;
   endfunction

   function automatic logic signed [63:0] sneg(input logic signed [63:0] a);
      return (a == S64_MIN) ? S64_MAX : -a;
   endfunction

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] r;
      unique case (i)
         5'd0:  r = 30'h3243F6A8;
         5'd1:  r = 30'h1DAC6705;
         5'd2:  r = 30'h0FADBAFC;
         5'd3:  r = 30'h07F56EA6;
         5'd4:  r = 30'h03FEAB76;
         5'd5:  r = 30'h01FFD55B;
         5'd6:  r = 30'h00FFFAAA;
         5'd7:  r = 30'h007FFF55;
         5'd8:  r = 30'h003FFFEA;
         5'd9:  r = 30'h001FFFFD;
         5'd10: r = 30'h000FFFFF;
         5'd11: r = 30'h0007FFFF;
         5'd12: r = 30'h0003FFFF;
         5'd13: r = 30'h0001FFFF;
         5'd14: r = 30'h0000FFFF;
         5'd15: r = 30'h00007FFF;
         5'd16: r = 30'h00003FFF;
         5'd17: r = 30'h00001FFF;
         5'd18: r = 30'h00000FFF;
         5'd19: r = 30'h000007FF;
         5'd20: r = 30'h000003FF;
         5'd21: r = 30'h000001FF;
         5'd22: r = 30'h000000FF;
         5'd23: r = 30'h0000007F;
         5'd24: r = 30'h0000003F;
         5'd25: r = 30'h0000001F;
         5'd26: r = 30'h0000000F;
         5'd27: r = 30'h00000008;
         5'd28: r = 30'h00000004;
         5'd29: r = 30'h00000002;
         5'd30: r = 30'h00000001;
         default: r = 30'h00000000;
      endcase
      return r;
   endfunction

   function automatic uinstr_type mk(input uop_type op, input logic [4:0] a,
                                     input logic [4:0] b, input logic [4:0] d);
      uinstr_type u;
      u.op = op;
      u.a  = a;
      u.b  = b;
      u.d  = d;
      return u;
   endfunction

   // sequencer program: limit preamble, then the side body run twice
   function automatic uinstr_type ucode(input logic [PC_W-1:0] pc);
      uinstr_type u;
      unique case (pc)
         7'd0:  u = mk(OP_LDF, F_RAT, NOREG, R_T1);
         7'd1:  u = mk(OP_LDF, F_INV, NOREG, R_T2);
         7'd2:  u = mk(OP_MUL, R_T1, R_T2, R_T1);
         7'd3:  u = mk(OP_MUL, R_T1, R_T1, R_SLIM);
         7'd4:  u = mk(OP_LDF, F_GS, NOREG, R_GS);
         7'd5:  u = mk(OP_LDF, F_BS, NOREG, R_BS);
         7'd6:  u = mk(OP_LDF, F_GT, NOREG, R_GT);
         7'd7:  u = mk(OP_LDF, F_BT, NOREG, R_BT);
         7'd8:  u = mk(OP_LDF, F_VN, NOREG, R_VN);
         7'd9:  u = mk(OP_LDF, F_VF, NOREG, R_VF);
         7'd10: u = mk(OP_TRIG, NOREG, NOREG, R_C);
         7'd11: u = mk(OP_MUL, R_VN, R_VF, R_VV);
         7'd12: u = mk(OP_MUL, R_VN, R_VN, R_VN2);
         7'd13: u = mk(OP_MUL, R_GT, R_C, R_T1);
         7'd14: u = mk(OP_MUL, R_BT, R_S, R_T2);
         7'd15: u = mk(OP_ADD, R_T1, R_T2, R_KA);
         7'd16: u = mk(OP_MUL, R_BT, R_C, R_T1);
         7'd17: u = mk(OP_NEG, R_T1, NOREG, R_T1);
         7'd18: u = mk(OP_MUL, R_GT, R_S, R_T2);
         7'd19: u = mk(OP_ADD, R_T1, R_T2, R_KB);
         7'd20: u = mk(OP_MUL, R_GS, R_VN2, R_T1);
         7'd21: u = mk(OP_MUL, R_VV, R_KA, R_T2);
         7'd22: u = mk(OP_ADD, R_T1, R_T2, R_P);
         7'd23: u = mk(OP_MUL, R_BS, R_VN2, R_T1);
         7'd24: u = mk(OP_NEG, R_T1, NOREG, R_T1);
         7'd25: u = mk(OP_MUL, R_VV, R_KB, R_T2);
         7'd26: u = mk(OP_ADD, R_T1, R_T2, R_Q);
         7'd27: u = mk(OP_MUL, R_VV, R_KB, R_DPFA);
         7'd28: u = mk(OP_NEG, R_DPFA, NOREG, R_DPNA);
         7'd29: u = mk(OP_MUL, R_VV, R_KA, R_DQNA);
         7'd30: u = mk(OP_NEG, R_DQNA, NOREG, R_DQFA);
         7'd31: u = mk(OP_ADD, R_GS, R_GS, R_T1);
         7'd32: u = mk(OP_MUL, R_T1, R_VN, R_T1);
         7'd33: u = mk(OP_MUL, R_VF, R_KA, R_T2);
         7'd34: u = mk(OP_ADD, R_T1, R_T2, R_DPNM);
         7'd35: u = mk(OP_MUL, R_VN, R_KA, R_DPFM);
         7'd36: u = mk(OP_ADD, R_BS, R_BS, R_T1);
         7'd37: u = mk(OP_MUL, R_T1, R_VN, R_T1);
         7'd38: u = mk(OP_NEG, R_T1, NOREG, R_T1);
         7'd39: u = mk(OP_MUL, R_VF, R_KB, R_T2);
         7'd40: u = mk(OP_ADD, R_T1, R_T2, R_DQNM);
         7'd41: u = mk(OP_MUL, R_VN, R_KB, R_DQFM);
         7'd42: u = mk(OP_MUL, R_P, R_P, R_T1);
         7'd43: u = mk(OP_MUL, R_Q, R_Q, R_T2);
         7'd44: u = mk(OP_ADD, R_T1, R_T2, R_S2);
         7'd45: u = mk(OP_MUL, R_P, R_DPNA, R_T1);
         7'd46: u = mk(OP_MUL, R_Q, R_DQNA, R_T2);
         7'd47: u = mk(OP_ADD, R_T1, R_T2, R_T1);
         7'd48: u = mk(OP_ADD, R_T1, R_T1, R_D0);
         7'd49: u = mk(OP_MUL, R_P, R_DPNM, R_T1);
         7'd50: u = mk(OP_MUL, R_Q, R_DQNM, R_T2);
         7'd51: u = mk(OP_ADD, R_T1, R_T2, R_T1);
         7'd52: u = mk(OP_ADD, R_T1, R_T1, R_D1);
         7'd53: u = mk(OP_MUL, R_P, R_DPFA, R_T1);
         7'd54: u = mk(OP_MUL, R_Q, R_DQFA, R_T2);
         7'd55: u = mk(OP_ADD, R_T1, R_T2, R_T1);
         7'd56: u = mk(OP_ADD, R_T1, R_T1, R_D2);
         7'd57: u = mk(OP_MUL, R_P, R_DPFM, R_T1);
         7'd58: u = mk(OP_MUL, R_Q, R_DQFM, R_T2);
         7'd59: u = mk(OP_ADD, R_T1, R_T2, R_T1);
         7'd60: u = mk(OP_ADD, R_T1, R_T1, R_D3);
         7'd61: u = mk(OP_EMV, R_S2, NOREG, SLOT_VAL);
         7'd62: u = mk(OP_EMV, R_D0, NOREG, SLOT_D0);
         7'd63: u = mk(OP_EMV, R_D1, NOREG, SLOT_D1);
         7'd64: u = mk(OP_EMV, R_D2, NOREG, SLOT_D2);
         7'd65: u = mk(OP_EMV, R_D3, NOREG, SLOT_D3);
         7'd66: u = mk(OP_PUSH, MARGIN_NO, NOREG, NOREG);
         7'd67: u = mk(OP_NEG, R_S2, NOREG, R_T1);
         7'd68: u = mk(OP_ADD, R_SLIM, R_T1, R_T1);
         7'd69: u = mk(OP_NEG, R_D0, NOREG, R_D0);
         7'd70: u = mk(OP_NEG, R_D1, NOREG, R_D1);
         7'd71: u = mk(OP_NEG, R_D2, NOREG, R_D2);
         7'd72: u = mk(OP_NEG, R_D3, NOREG, R_D3);
         7'd73: u = mk(OP_EMV, R_T1, NOREG, SLOT_VAL);
         7'd74: u = mk(OP_EMV, R_D0, NOREG, SLOT_D0);
         7'd75: u = mk(OP_EMV, R_D1, NOREG, SLOT_D1);
         7'd76: u = mk(OP_EMV, R_D2, NOREG, SLOT_D2);
         7'd77: u = mk(OP_EMV, R_D3, NOREG, SLOT_D3);
         7'd78: u = mk(OP_PUSH, MARGIN_YES, NOREG, NOREG);
         default: u = mk(OP_NEXT, NOREG, NOREG, NOREG);
      endcase
      return u;
   endfunction

endpackage

// File: hw/rtl/bflj_mul.sv
module bflj_mul #(
   parameter int FRAC_BITS = bflj_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic               done,
   output logic signed [63:0] result
);
   import bflj_pkg::*;

   logic [63:0]  ua_ff, ua_in, ub_ff, ub_in;
   logic         neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   step_ff, step_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic signed [63:0] res_ff, res_in;

   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [127:0] q;

   always_comb begin
      unique case (step_ff[1:0])
         2'd0: pp = 64'(ua_ff[31:0]) * 64'(ub_ff[31:0]);
         2'd1: pp = 64'(ua_ff[63:32]) * 64'(ub_ff[31:0]);
         2'd2: pp = 64'(ua_ff[31:0]) * 64'(ub_ff[63:32]);
         default: pp = 64'(ua_ff[63:32]) * 64'(ub_ff[63:32]);
      endcase
      unique case (step_ff[1:0])
         2'd0: pp_sh = {64'd0, pp};
         2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
         default: pp_sh = {pp, 64'd0};
      endcase
      q = acc_ff >> FRAC_BITS;
   end

   always_comb begin
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         ua_in   = a[63] ? 64'd0 - a : a;
         ub_in   = b[63] ? 64'd0 - b : b;
         neg_in  = a[63] != b[63];
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff[2]) begin
            // truncate toward zero on the magnitude, then saturate
            if (|q[127:63]) res_in = neg_ff ? S64_MIN : S64_MAX;
            else res_in = neg_ff ? -$signed(q[63:0]) : $signed(q[63:0]);
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            acc_in  = acc_ff + pp_sh;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

// File: hw/rtl/bflj_cordic.sv
module bflj_cordic #(
   parameter int FRAC_BITS       = bflj_pkg::FRAC_BITS_DEF,
   parameter int TRIG_ITERATIONS = bflj_pkg::TRIG_ITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] theta,
   output logic               done,
   output logic signed [63:0] cos_out,
   output logic signed [63:0] sin_out
);
   import bflj_pkg::*;

   localparam int SH     = 30 - FRAC_BITS;
   localparam int NITER  = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;
   localparam int RK     = 34;
   localparam logic [33:0] TWO_PI_U   = 34'(Q30_TWO_PI);
   localparam logic [63:0] RECIP_FULL = (64'd1 << (RK + SH)) / 64'(TWO_PI_U);
   localparam logic [23:0] RECIP      = RECIP_FULL[23:0];

   typedef enum logic [6:0] {
      C_IDLE = 7'b0000001,
      C_QUO  = 7'b0000010,
      C_SUB  = 7'b0000100,
      C_FIX  = 7'b0001000,
      C_FOLD = 7'b0010000,
      C_ROT  = 7'b0100000,
      C_FIN  = 7'b1000000
   } cor_state_type;

   cor_state_type state_ff, state_in;
   logic [32:0]   tm_ff, tm_in;
   logic [22:0]   quo_ff, quo_in;
   logic [63:0]   rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic          flip_ff, flip_in;
   logic [4:0]    icnt_ff, icnt_in;
   logic signed [63:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [63:0] cos_ff, cos_in, sin_ff, sin_in;
   logic          done_ff, done_in;

   logic [32:0]        tmag;
   logic [56:0]        qprod;
   logic [63:0]        qt;
   logic signed [63:0] r0, r1, dx, dy, at, xf, yf;

   always_comb begin
      tmag  = theta[32] ? 33'd0 - theta : theta;
      qprod = 57'(tm_ff) * 57'(RECIP);
      qt    = 64'(quo_ff) * 64'(TWO_PI_U);
      r0    = neg_ff ? -$signed(rem_ff) : $signed(rem_ff);
      if (r0 > Q30_PI) r1 = r0 - Q30_TWO_PI;
      else if (r0 < -Q30_PI) r1 = r0 + Q30_TWO_PI;
      else r1 = r0;
      dx = y_ff >>> icnt_ff;
      dy = x_ff >>> icnt_ff;
      at = 64'(atan_q30(icnt_ff));
      xf = flip_ff ? -x_ff : x_ff;
      yf = flip_ff ? -y_ff : y_ff;
   end

   always_comb begin
      state_in = state_ff;
      tm_in    = tm_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      flip_in  = flip_ff;
      icnt_in  = icnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               tm_in    = tmag;
               neg_in   = theta[32];
               state_in = C_QUO;
            end
         end
         C_QUO: begin
            // estimate the quotient by 2*pi with a reciprocal; at most one low
            quo_in   = qprod[56:RK];
            rem_in   = 64'(tm_ff) << SH;
            state_in = C_SUB;
         end
         C_SUB: begin
            rem_in   = rem_ff - qt;
            state_in = C_FIX;
         end
         C_FIX: begin
            if (rem_ff >= 64'(TWO_PI_U)) rem_in = rem_ff - 64'(TWO_PI_U);
            state_in = C_FOLD;
         end
         C_FOLD: begin
            flip_in = 1'b0;
            z_in    = r1;
            if (r1 > Q30_HALF_PI) begin
               z_in    = r1 - Q30_PI;
               flip_in = 1'b1;
            end else if (r1 < -Q30_HALF_PI) begin
               z_in    = r1 + Q30_PI;
               flip_in = 1'b1;
            end
            x_in     = Q30_GAIN;
            y_in     = '0;
            icnt_in  = '0;
            state_in = C_ROT;
         end
         C_ROT: begin
            if (!z_ff[63]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
            if (icnt_ff == 5'(NITER - 1)) state_in = C_FIN;
            else icnt_in = icnt_ff + 5'd1;
         end
         C_FIN: begin
            cos_in   = xf >>> SH;
            sin_in   = yf >>> SH;
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      tm_ff   <= tm_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      flip_ff <= flip_in;
      icnt_ff <= icnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule

// File: hw/rtl/bflj_front.sv
module bflj_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [415:0]       req_tdata,
   input  logic               req_tuser,
   output logic               head_valid,
   output bflj_pkg::item_type head,
   input  logic               head_pop
);
   import bflj_pkg::*;

   item_type   q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   item;

   // split the packed transaction into admittance halves and bus values
   always_comb begin
      item.gff    = req_tdata[63:32];
      item.bff    = req_tdata[31:0];
      item.gft    = req_tdata[127:96];
      item.bft    = req_tdata[95:64];
      item.gtf    = req_tdata[191:160];
      item.btf    = req_tdata[159:128];
      item.gtt    = req_tdata[255:224];
      item.btt    = req_tdata[223:192];
      item.af     = req_tdata[287:256];
      item.vmf    = req_tdata[319:288];
      item.at     = req_tdata[351:320];
      item.vmt    = req_tdata[383:352];
      item.rating = req_tdata[414:384];
      item.on     = req_tuser;
   end

   assign req_tready = cnt_ff != 2'd2;
   assign push       = req_tvalid && req_tready;
   assign head_valid = cnt_ff != 2'd0;
   assign head       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = head_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= item;
   end
endmodule

// File: hw/rtl/bflj_engine.sv
module bflj_engine #(
   parameter int FRAC_BITS       = bflj_pkg::FRAC_BITS_DEF,
   parameter int TRIG_ITERATIONS = bflj_pkg::TRIG_ITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  bflj_pkg::item_type head,
   output logic               head_pop,
   input  logic [30:0]        inv_mva,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bflj_pkg::row_type  rsp_row
);
   import bflj_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FETCH = 6'b000010,
      S_EXEC  = 6'b000100,
      S_MULW  = 6'b001000,
      S_TRIGW = 6'b010000,
      S_TRIGS = 6'b100000
   } eng_state_type;

   eng_state_type      state_ff, state_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic               side_ff, side_in;
   logic signed [63:0] rf_ff [32];
   logic signed [63:0] rd_a_ff, rd_b_ff;
   logic signed [63:0] slot_ff [5];
   row_type            oq_ff [2];
   logic               oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [1:0]         oq_cnt_ff, oq_cnt_in;

   uinstr_type         uc;
   logic               wr_en;
   logic [4:0]         wr_addr;
   logic signed [63:0] wr_data;
   logic               mul_start, mul_done, trig_start, trig_done;
   logic signed [63:0] mul_res, cos_v, sin_v;
   logic signed [32:0] theta;
   logic signed [63:0] fld;
   logic               emv_en, push, oq_pop, oq_full;
   row_type            row;

   assign uc = ucode(pc_ff);

   assign theta = side_ff ? 33'({head.at[31], head.at} - {head.af[31], head.af})
                          : 33'({head.af[31], head.af} - {head.at[31], head.at});

   // near and far operands swap on the to side
   always_comb begin
      unique case (uc.a)
         F_GS:  fld = 64'(side_ff ? head.gtt : head.gff);
         F_BS:  fld = 64'(side_ff ? head.btt : head.bff);
         F_GT:  fld = 64'(side_ff ? head.gtf : head.gft);
         F_BT:  fld = 64'(side_ff ? head.btf : head.bft);
         F_VN:  fld = 64'(side_ff ? head.vmt : head.vmf);
         F_VF:  fld = 64'(side_ff ? head.vmf : head.vmt);
         F_RAT: fld = {33'd0, head.rating};
         default: fld = {33'd0, inv_mva};
      endcase
   end

   bflj_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (rd_a_ff),
      .b      (rd_b_ff),
      .done   (mul_done),
      .result (mul_res)
   );

   bflj_cordic #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .theta   (theta),
      .done    (trig_done),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   assign oq_full   = oq_cnt_ff == 2'd2;
   assign rsp_valid = oq_cnt_ff != 2'd0;
   assign oq_pop    = rsp_valid && rsp_ready;
   assign rsp_row   = oq_ff[oq_rd_ff];

   always_comb begin
      row.kind  = {side_ff, uc.a[0]};
      row.last  = side_ff & uc.a[0];
      row.value = head.on ? slot_ff[0] : 64'sd0;
      row.dna   = slot_ff[1];
      row.dnm   = slot_ff[2];
      row.dfa   = slot_ff[3];
      row.dfm   = slot_ff[4];
   end

   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      side_in    = side_ff;
      wr_en      = 1'b0;
      wr_addr    = uc.d;
      wr_data    = '0;
      mul_start  = 1'b0;
      trig_start = 1'b0;
      emv_en     = 1'b0;
      push       = 1'b0;
      head_pop   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pc_in    = '0;
               side_in  = 1'b0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_EXEC;
         S_EXEC: begin
            unique case (uc.op)
               OP_LDF: begin
                  wr_en    = 1'b1;
                  wr_data  = fld;
                  pc_in    = pc_ff + PC_W'(1);
                  state_in = S_FETCH;
               end
               OP_ADD: begin
                  wr_en    = 1'b1;
                  wr_data  = sadd(rd_a_ff, rd_b_ff);
                  pc_in    = pc_ff + PC_W'(1);
                  state_in = S_FETCH;
               end
               OP_NEG: begin
                  wr_en    = 1'b1;
                  wr_data  = sneg(rd_a_ff);
                  pc_in    = pc_ff + PC_W'(1);
                  state_in = S_FETCH;
               end
               OP_MUL: begin
                  mul_start = 1'b1;
                  state_in  = S_MULW;
               end
               OP_TRIG: begin
                  trig_start = 1'b1;
                  state_in   = S_TRIGW;
               end
               OP_EMV: begin
                  emv_en   = 1'b1;
                  pc_in    = pc_ff + PC_W'(1);
                  state_in = S_FETCH;
               end
               OP_PUSH: begin
                  // hold until the result queue has room
                  if (!oq_full) begin
                     push     = 1'b1;
                     pc_in    = pc_ff + PC_W'(1);
                     state_in = S_FETCH;
                  end
               end
               OP_NEXT: begin
                  if (!side_ff) begin
                     side_in  = 1'b1;
                     pc_in    = BODY_PC;
                     state_in = S_FETCH;
                  end else begin
                     head_pop = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_MULW: begin
            if (mul_done) begin
               wr_en    = 1'b1;
               wr_data  = mul_res;
               pc_in    = pc_ff + PC_W'(1);
               state_in = S_FETCH;
            end
         end
         S_TRIGW: begin
            if (trig_done) begin
               wr_en    = 1'b1;
               wr_addr  = R_C;
               wr_data  = cos_v;
               state_in = S_TRIGS;
            end
         end
         S_TRIGS: begin
            wr_en    = 1'b1;
            wr_addr  = R_S;
            wr_data  = sin_v;
            pc_in    = pc_ff + PC_W'(1);
            state_in = S_FETCH;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      oq_wr_in  = push ? ~oq_wr_ff : oq_wr_ff;
      oq_rd_in  = oq_pop ? ~oq_rd_ff : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + 2'(push) - 2'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pc_ff     <= '0;
         side_ff   <= 1'b0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         side_ff   <= side_in;
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   // scratch register file: one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) rf_ff[wr_addr] <= wr_data;
      rd_a_ff <= rf_ff[uc.a];
      rd_b_ff <= rf_ff[uc.b];
   end

   always_ff @(posedge clock) begin
      if (emv_en) slot_ff[uc.d[2:0]] <= rd_a_ff;
      if (push) oq_ff[oq_wr_ff] <= row;
   end
endmodule

// File: hw/rtl/branch_flow_limit_and_jacobian_top.sv
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  req_tdata: branch, req_tuser: in service
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata: row, rsp_tuser: kind, rsp_tlast
// csr       in   csr_wr_en              csr_wr_data: inv_mva_base
//
// Each branch runs its 58 products on the one shared multiplier and makes two
// CORDIC calls, one per side; the sequencer does every other micro-op itself.
// A two-entry input queue accepts branches while the engine works; a two-entry
// result queue lets the engine run ahead of a stalled consumer.
// Reset is synchronous; it empties both queues and idles the sequencer.
module branch_flow_limit_and_jacobian_top #(
   parameter int FRAC_BITS       = bflj_pkg::FRAC_BITS_DEF,
   parameter int TRIG_ITERATIONS = bflj_pkg::TRIG_ITER_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // y_from_from, y_from_to, y_to_from, y_to_to, angle_from, magnitude_from,
   // angle_to, magnitude_to, rating, one zero pad bit
   input  logic [415:0] req_tdata,
   // in_service
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // constraint_value, d_near_angle, d_near_magnitude, d_far_angle, d_far_magnitude
   output logic [319:0] rsp_tdata,
   // row_kind
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [30:0]  csr_wr_data
);
   import bflj_pkg::*;

   logic [30:0] inv_mva_ff, inv_mva_in;
   logic        head_valid, head_pop;
   item_type    head;
   row_type     row;

   assign inv_mva_in = csr_wr_en ? csr_wr_data : inv_mva_ff;

   always_ff @(posedge clock) begin
      if (reset) inv_mva_ff <= INV_MVA_RESET;
      else inv_mva_ff <= inv_mva_in;
   end

   bflj_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   bflj_engine #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .inv_mva    (inv_mva_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_row    (row)
   );

   assign rsp_tdata = {row.dfm, row.dfa, row.dnm, row.dna, row.value};
   assign rsp_tuser = row.kind;
   assign rsp_tlast = row.last;

   a_last_on_to_margin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_TO_MARGIN)))
      else $error("tlast does not match the to-side margin row");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && req_tready))
      else $error("queues not empty after reset");
endmodule

// File: dv/branch_flow_limit_and_jacobian_top_tb.sv
module branch_flow_limit_and_jacobian_top_tb;
   import bflj_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int ROTATIONS = (TRIG_ITER_DEF < 32) ? TRIG_ITER_DEF : 32;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 1600;
   localparam int LONG_HOLD_CYCLES = 3000;

   localparam logic [29:0] ATAN_STEP [32] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
      30'h00000001, 30'h00000000};

   typedef struct {
      logic [63:0] y_ff, y_ft, y_tf, y_tt;
      logic [31:0] ang_f, mag_f, ang_t, mag_t;
      logic [30:0] rating;
      logic        in_service;
   } branch_type;

   typedef struct {
      logic signed [63:0] s2;
      logic signed [63:0] d [4];
   } side_type;

   class flow_scoreboard;
      row_type    pending_rows[$];
      logic [30:0] inv_mva;
      int         errors;

      function new();
         inv_mva = INV_MVA_RESET;
         errors = 0;
      endfunction

      function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
         logic signed [64:0] s;
         s = {a[63], a} + {b[63], b};
         if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
         if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
         return s[63:0];
      endfunction

      function logic signed [63:0] sat_neg(logic signed [63:0] a);
         return (a == S64_MIN) ? S64_MAX : -a;
      endfunction

      // exact product, truncate toward zero, then saturate
      function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
         logic [63:0]  ua, ub;
         logic [127:0] pr;
         logic         neg;
         neg = a[63] ^ b[63];
         ua = a[63] ? 64'(-a) : 64'(a);
         ub = b[63] ? 64'(-b) : 64'(b);
         pr = ({64'd0, ua} * {64'd0, ub}) >> FRAC;
         if (!neg) return (pr > 128'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : pr[63:0];
         return (pr >= 128'h8000_0000_0000_0000) ? S64_MIN : -$signed(pr[63:0]);
      endfunction

      function void cordic(logic signed [63:0] theta, output logic signed [63:0] c,
                           output logic signed [63:0] s);
         logic signed [63:0] a, r, x, y, z, dx, dy;
         logic               flip;
         a = theta * (64'sd1 <<< (30 - FRAC));
         r = a - (a / Q30_TWO_PI) * Q30_TWO_PI;
         flip = 1'b0;
         if (r > Q30_PI) r = r - Q30_TWO_PI;
         if (r < -Q30_PI) r = r + Q30_TWO_PI;
         if (r > Q30_HALF_PI) begin
            r = r - Q30_PI;
            flip = 1'b1;
         end else if (r < -Q30_HALF_PI) begin
            r = r + Q30_PI;
            flip = 1'b1;
         end
         x = Q30_GAIN;
         y = 64'sd0;
         z = r;
         for (int i = 0; i < ROTATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - $signed({34'd0, ATAN_STEP[i]});
            end else begin
               x = x + dx; y = y - dy; z = z + $signed({34'd0, ATAN_STEP[i]});
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         c = x >>> (30 - FRAC);
         s = y >>> (30 - FRAC);
      endfunction

      function logic signed [63:0] grad(logic signed [63:0] p, logic signed [63:0] dp,
                                        logic signed [63:0] q, logic signed [63:0] dq);
         logic signed [63:0] t;
         t = sat_add(qmul(p, dp), qmul(q, dq));
         return sat_add(t, t);
      endfunction

      function side_type end_flow(logic [63:0] y_self, logic [63:0] y_xfer,
                                  logic signed [63:0] vn, logic signed [63:0] vf,
                                  logic signed [63:0] theta);
         logic signed [63:0] gs, bs, gt, bt, c, s, vv, vn2, ka, kb, p, q;
         logic signed [63:0] dpna, dpnm, dpfa, dpfm, dqna, dqnm, dqfa, dqfm;
         side_type o;
         gs = $signed(y_self[63:32]);
         bs = $signed(y_self[31:0]);
         gt = $signed(y_xfer[63:32]);
         bt = $signed(y_xfer[31:0]);
         cordic(theta, c, s);
         vv = qmul(vn, vf);
         vn2 = qmul(vn, vn);
         ka = sat_add(qmul(gt, c), qmul(bt, s));
         kb = sat_add(sat_neg(qmul(bt, c)), qmul(gt, s));
         p = sat_add(qmul(gs, vn2), qmul(vv, ka));
         q = sat_add(sat_neg(qmul(bs, vn2)), qmul(vv, kb));
         dpfa = qmul(vv, kb);
         dpna = sat_neg(dpfa);
         dqna = qmul(vv, ka);
         dqfa = sat_neg(dqna);
         dpnm = sat_add(qmul(sat_add(gs, gs), vn), qmul(vf, ka));
         dpfm = qmul(vn, ka);
         dqnm = sat_add(sat_neg(qmul(sat_add(bs, bs), vn)), qmul(vf, kb));
         dqfm = qmul(vn, kb);
         o.s2 = sat_add(qmul(p, p), qmul(q, q));
         o.d[0] = grad(p, dpna, q, dqna);
         o.d[1] = grad(p, dpnm, q, dqnm);
         o.d[2] = grad(p, dpfa, q, dqfa);
         o.d[3] = grad(p, dpfm, q, dqfm);
         return o;
      endfunction

      function void note_branch(branch_type b);
         logic signed [63:0] af, at, vmf, vmt, rpu, slim2, val;
         side_type sd [2];
         row_type  r;
         af = $signed(b.ang_f);
         at = $signed(b.ang_t);
         vmf = $signed(b.mag_f);
         vmt = $signed(b.mag_t);
         sd[0] = end_flow(b.y_ff, b.y_ft, vmf, vmt, af - at);
         sd[1] = end_flow(b.y_tt, b.y_tf, vmt, vmf, at - af);
         rpu = qmul({33'd0, b.rating}, {33'd0, inv_mva});
         slim2 = qmul(rpu, rpu);
         for (int k = 0; k < 4; k++) begin
            val = k[0] ? sat_add(slim2, sat_neg(sd[k >> 1].s2)) : sd[k >> 1].s2;
            r.kind = k[1:0];
            r.last = (k[1:0] == KIND_TO_MARGIN);
            r.value = b.in_service ? val : 64'sd0;
            r.dna = k[0] ? sat_neg(sd[k >> 1].d[0]) : sd[k >> 1].d[0];
            r.dnm = k[0] ? sat_neg(sd[k >> 1].d[1]) : sd[k >> 1].d[1];
            r.dfa = k[0] ? sat_neg(sd[k >> 1].d[2]) : sd[k >> 1].d[2];
            r.dfm = k[0] ? sat_neg(sd[k >> 1].d[3]) : sd[k >> 1].d[3];
            pending_rows.push_back(r);
         end
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("MISMATCH %s: got %h expected %h", what, got, want);
         errors++;
      endtask

      task check_row(row_type got);
         row_type want;
         if (pending_rows.size() == 0) begin
            report_mismatch("unexpected row", got.value, 64'd0);
            return;
         end
         want = pending_rows.pop_front();
         if (got.kind !== want.kind) report_mismatch("row_kind", got.kind, want.kind);
         if (got.last !== want.last) report_mismatch("last", got.last, want.last);
         if (got.value !== want.value) report_mismatch("constraint_value", got.value, want.value);
         if (got.dna !== want.dna) report_mismatch("d_near_angle", got.dna, want.dna);
         if (got.dnm !== want.dnm) report_mismatch("d_near_magnitude", got.dnm, want.dnm);
         if (got.dfa !== want.dfa) report_mismatch("d_far_angle", got.dfa, want.dfa);
         if (got.dfm !== want.dfm) report_mismatch("d_far_magnitude", got.dfm, want.dfm);
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [415:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [319:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wr_en;
   logic [30:0]  csr_wr_data;

   flow_scoreboard sb = new();
   bit     quiet_tail;
   bit     long_hold_req;
   longint cycles;

   branch_flow_limit_and_jacobian_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("branch_flow_limit_and_jacobian_top regression: fail");
            $finish;
         end
      end
   end

   // observe every transaction on all three ports
   always @(posedge clock) begin
      branch_type b;
      row_type    r;
      if (!reset) begin
         if (csr_wr_en) sb.inv_mva = csr_wr_data;
         if (req_tvalid && req_tready) begin
            b.y_ff = req_tdata[63:0];
            b.y_ft = req_tdata[127:64];
            b.y_tf = req_tdata[191:128];
            b.y_tt = req_tdata[255:192];
            b.ang_f = req_tdata[287:256];
            b.mag_f = req_tdata[319:288];
            b.ang_t = req_tdata[351:320];
            b.mag_t = req_tdata[383:352];
            b.rating = req_tdata[414:384];
            b.in_service = req_tuser;
            sb.note_branch(b);
         end
         if (rsp_tvalid && rsp_tready) begin
            r.kind = rsp_tuser;
            r.last = rsp_tlast;
            r.value = rsp_tdata[63:0];
            r.dna = rsp_tdata[127:64];
            r.dnm = rsp_tdata[191:128];
            r.dfa = rsp_tdata[255:192];
            r.dfm = rsp_tdata[319:256];
            sb.check_row(r);
         end
      end
   end

   // result side backpressure
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] near_value(logic [31:0] center, int unsigned spread);
      return center + $urandom_range(0, 2 * spread) - spread;
   endfunction

   function automatic branch_type random_branch();
      branch_type b;
      if ($urandom_range(0, 9) < 2) begin
         // raw noise over every bit
         b.y_ff = {$urandom, $urandom};
         b.y_ft = {$urandom, $urandom};
         b.y_tf = {$urandom, $urandom};
         b.y_tt = {$urandom, $urandom};
         b.ang_f = $urandom;
         b.mag_f = $urandom;
         b.ang_t = $urandom;
         b.mag_t = $urandom;
         b.rating = 31'($urandom);
      end else begin
         b.y_ff = {near_value(0, 30 << 20), near_value(0, 30 << 20)};
         b.y_ft = {near_value(0, 30 << 20), near_value(0, 30 << 20)};
         b.y_tf = {near_value(0, 30 << 20), near_value(0, 30 << 20)};
         b.y_tt = {near_value(0, 30 << 20), near_value(0, 30 << 20)};
         b.ang_f = near_value(0, 3 << 20);
         b.ang_t = near_value(0, 3 << 20);
         b.mag_f = near_value(1 << 20, 1 << 17);
         b.mag_t = near_value(1 << 20, 1 << 17);
         b.rating = 31'($urandom_range(0, 3000) << 20);
      end
      b.in_service = ($urandom_range(0, 9) != 0);
      return b;
   endfunction

   function automatic branch_type flat_branch(logic [31:0] y, logic [31:0] ang_f,
                                              logic [31:0] ang_t, logic [31:0] mag,
                                              logic [30:0] rating, logic on);
      branch_type b;
      b.y_ff = {y, y};
      b.y_ft = {y, ~y};
      b.y_tf = {~y, y};
      b.y_tt = {y, y};
      b.ang_f = ang_f;
      b.ang_t = ang_t;
      b.mag_f = mag;
      b.mag_t = mag;
      b.rating = rating;
      b.in_service = on;
      return b;
   endfunction

   task send_branch(branch_type b);
      req_tdata <= {1'b0, b.rating, b.mag_t, b.ang_t, b.mag_f, b.ang_f,
                    b.y_tt, b.y_tf, b.y_ft, b.y_ff};
      req_tuser <= b.in_service;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task send_with_gaps(branch_type b);
      send_branch(b);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold input idle until every expected row has come back, then write
   task write_inv_mva(logic [30:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rows.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task run_random(int count);
      repeat (count) send_with_gaps(random_branch());
   endtask

   initial begin
      branch_type b;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      quiet_tail = 1'b0;
      long_hold_req = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners under the reset value of the register
      send_with_gaps(flat_branch(32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0));
      send_with_gaps(flat_branch(32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b1));
      send_with_gaps(flat_branch('1, '1, '1, '1, '1, 1'b1));
      send_with_gaps(flat_branch(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                 32'h7FFFFFFF, 31'h7FFFFFFF, 1'b1));
      send_with_gaps(flat_branch(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                 32'h80000000, 31'h7FFFFFFF, 1'b1));
      send_with_gaps(flat_branch(32'h80000000, 32'h0, 32'h0, 32'h7FFFFFFF, 31'h0, 1'b0));
      // angle differences near pi, -pi, pi/2 and one past forty pi
      send_with_gaps(flat_branch(32'h00100000, 32'd3294199, 32'h0, 32'h00100000,
                                 31'h3E800000, 1'b1));
      send_with_gaps(flat_branch(32'h00100000, 32'h0, 32'd3294199, 32'h00100000,
                                 31'h3E800000, 1'b1));
      send_with_gaps(flat_branch(32'h00100000, 32'd1647099, 32'h0, 32'h00100000,
                                 31'h3E800000, 1'b1));
      send_with_gaps(flat_branch(32'h00100000, 32'd1647100, 32'h0, 32'h00100000,
                                 31'h3E800000, 1'b1));
      send_with_gaps(flat_branch(32'h00300000, 32'd65868000, 32'hFC000000, 32'h00100000,
                                 31'h06400000, 1'b1));
      // negative magnitudes, used as given
      send_with_gaps(flat_branch(32'h00A00000, 32'h00080000, 32'hFFF80000, 32'hFFF00000,
                                 31'h00100000, 1'b1));
      b = random_branch();
      b.in_service = 1'b0;
      send_with_gaps(b);
      repeat (7) send_with_gaps(random_branch());

      write_inv_mva(31'd0);
      run_random(60);

      write_inv_mva(31'h7FFFFFFF);
      long_hold_req = 1'b1;
      run_random(60);

      write_inv_mva(31'($urandom));
      run_random(140);

      write_inv_mva(INV_MVA_RESET);
      quiet_tail = 1'b1;
      run_random(130);
      req_tvalid <= 1'b0;

      while (sb.pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_rows.size() == 0)
         $display("branch_flow_limit_and_jacobian_top regression: pass");
      else
         $display("branch_flow_limit_and_jacobian_top regression: fail");
      $finish;
   end
endmodule
